// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
// each macro expects clk and rst_n in scope of the user
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/fct_pkg.sv =====
// shared types, codes and constants of the fat12 cluster table engine
// no dependencies
package fct_pkg;

  localparam int MAX_ENTRIES_DEF = 4096;

  localparam int ENTRY_W = 12;
  localparam int OP_W    = 2;
  localparam int ST_W    = 2;
  localparam int SECT_W  = 4;
  // wide enough for the uncapped limit and for a zero-extended cluster
  localparam int CMP_W   = 13;

  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd2;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_LOOP  = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  localparam logic [ENTRY_W-1:0] END_MARK  = 12'hFFF;
  localparam logic [ENTRY_W-1:0] CHAIN_TOP = 12'hFF0;

  localparam logic [SECT_W-1:0] FAT_SECTORS_RST = 4'd9;

  // sectors*1024/3, one entry per sector count
  function automatic logic [CMP_W-1:0] raw_limit(input logic [SECT_W-1:0] sectors);
    logic [CMP_W-1:0] lim;
    case (sectors)
      4'd0:    lim = 13'd0;
      4'd1:    lim = 13'd341;
      4'd2:    lim = 13'd682;
      4'd3:    lim = 13'd1024;
      4'd4:    lim = 13'd1365;
      4'd5:    lim = 13'd1706;
      4'd6:    lim = 13'd2048;
      4'd7:    lim = 13'd2389;
      4'd8:    lim = 13'd2730;
      4'd9:    lim = 13'd3072;
      4'd10:   lim = 13'd3413;
      4'd11:   lim = 13'd3754;
      4'd12:   lim = 13'd4096;
      4'd13:   lim = 13'd4437;
      4'd14:   lim = 13'd4778;
      default: lim = 13'd5120;
    endcase
    return lim;
  endfunction

  // cluster values that end a chain walk
  function automatic logic chain_end(input logic [ENTRY_W-1:0] cl);
    return (cl < 12'd2) || (cl >= CHAIN_TOP);
  endfunction

endpackage

// ===== rtl/fct_if.sv =====
// valid/ready channels of the fat12 cluster table engine
// depends on fct_pkg for field widths
interface fct_req_if;
  logic                         valid;
  logic                         ready;
  logic [fct_pkg::OP_W-1:0]     op;
  logic [fct_pkg::ENTRY_W-1:0]  cluster;
  logic [fct_pkg::ENTRY_W-1:0]  entry_value;

  modport source(output valid, output op, output cluster, output entry_value, input ready);
  modport sink(input valid, input op, input cluster, input entry_value, output ready);
endinterface

interface fct_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [fct_pkg::ENTRY_W-1:0]  result_value;
  logic [fct_pkg::ST_W-1:0]     status;

  modport source(output valid, output result_value, output status, input ready);
  modport sink(input valid, input result_value, input status, output ready);
endinterface

// ===== rtl/fat12_cluster_table_engine_top.sv =====
// top level of the fat12 cluster table engine: table memory and request sequencer
// depends on fct_pkg, fct_if.sv and assert_macros.svh
//
// usage: requests arrive as words on in_ch (op, cluster, entry_value) and each
// one gives exactly one result word on out_ch (result_value, status), in order.
// cfg_we/cfg_wdata set the sectors per fat copy; write it only while idle.
// steps from the accepting edge to the result being offered:
//   write, out-of-range access, chain terminator: answered from the idle state
//   read: one synchronous memory round trip, then the read state answers
//   allocate: one read per entry examined from cluster 2 upward
//   free chain: one read and one zeroing write per entry freed
// the table is a single 12-bit memory with one read and one write port; the
// scan and the chain walk read one entry per cycle, so allocate and free are
// paced by that read port. a chain step that revisits the entry just zeroed
// is forwarded as zero.
// reset: after rst_n is released a clearing pass zeroes MAX_ENTRIES entries,
// one per cycle, during which in_ch.ready is low; config writes still land.
// a stalled out_ch holds its word in the output register; one more request
// is taken meanwhile and waits for the output register before it completes.
`include "assert_macros.svh"

module fat12_cluster_table_engine_top #(
  parameter int MAX_ENTRIES = fct_pkg::MAX_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  fct_req_if.sink                     in_ch,
  fct_rsp_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [fct_pkg::SECT_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int LW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = fct_pkg::ENTRY_W;
  localparam int CW = fct_pkg::CMP_W;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_ALLOC = 6'b001000,
    S_FREE  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [EW-1:0] mem [MAX_ENTRIES];
  logic [EW-1:0] rdata_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata;

  logic [LW-1:0] lim_r, lim_nxt, lim_rst;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] a_r, a_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic          fwd_r, fwd_nxt;
  logic [EW-1:0] res_r;
  logic [fct_pkg::ST_W-1:0] st_r;

  logic          out_valid_r, out_valid_nxt;
  logic [EW-1:0] out_res_r;
  logic [fct_pkg::ST_W-1:0] out_st_r;

  logic          in_acc, in_rng, slot_free, out_load;
  logic [AW-1:0] cl_addr, next_addr;
  logic [EW-1:0] walk_d;
  logic          fin;
  logic [EW-1:0] fin_res;
  logic [fct_pkg::ST_W-1:0] fin_st;

  function automatic logic [LW-1:0] cap_limit(input logic [CW-1:0] raw);
    return (raw > CW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES) : LW'(raw);
  endfunction

  assign lim_rst = cap_limit(fct_pkg::raw_limit(fct_pkg::FAT_SECTORS_RST));
  assign lim_nxt = cfg_we ? cap_limit(fct_pkg::raw_limit(cfg_wdata)) : lim_r;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_rng      = {1'b0, in_ch.cluster} < CW'(lim_r);
  assign cl_addr     = in_ch.cluster[AW-1:0];
  assign slot_free   = !out_valid_r || out_ch.ready;

  assign next_addr = a_r + AW'(1);
  assign walk_d    = fwd_r ? '0 : rdata_r;
  assign cnt_inc   = cnt_r + LW'(1);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    a_nxt     = a_r;
    cnt_nxt   = cnt_r;
    fwd_nxt   = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = a_r;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = a_r;
    fin       = 1'b0;
    fin_res   = '0;
    fin_st    = fct_pkg::ST_OK;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        if (clr_r == AW'(MAX_ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.op)
            fct_pkg::OP_READ: begin
              if (in_rng) begin
                mem_re    = 1'b1;
                mem_raddr = cl_addr;
                state_nxt = S_READ;
              end else begin
                fin    = 1'b1;
                fin_st = fct_pkg::ST_RANGE;
              end
            end
            fct_pkg::OP_WRITE: begin
              fin = 1'b1;
              if (in_rng) begin
                mem_we    = 1'b1;
                mem_waddr = cl_addr;
                mem_wdata = in_ch.entry_value;
              end else begin
                fin_st = fct_pkg::ST_RANGE;
              end
            end
            fct_pkg::OP_ALLOC: begin
              if (lim_r <= LW'(2)) begin
                fin    = 1'b1;
                fin_st = fct_pkg::ST_FULL;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = AW'(2);
                a_nxt     = AW'(2);
                state_nxt = S_ALLOC;
              end
            end
            fct_pkg::OP_FREE: begin
              if (fct_pkg::chain_end(in_ch.cluster)) begin
                fin = 1'b1;
              end else if (!in_rng) begin
                fin    = 1'b1;
                fin_st = fct_pkg::ST_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = cl_addr;
                a_nxt     = cl_addr;
                cnt_nxt   = '0;
                state_nxt = S_FREE;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        fin     = 1'b1;
        fin_res = rdata_r;
      end
      S_ALLOC: begin
        // rdata_r holds entry a_r
        if (rdata_r == '0) begin
          mem_we    = 1'b1;
          mem_waddr = a_r;
          mem_wdata = fct_pkg::END_MARK;
          fin       = 1'b1;
          fin_res   = EW'(a_r);
        end else if ((LW'(a_r) + LW'(1)) == lim_r) begin
          fin    = 1'b1;
          fin_st = fct_pkg::ST_FULL;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = next_addr;
          a_nxt     = next_addr;
        end
      end
      S_FREE: begin
        // zero the current entry and follow its link
        mem_we    = 1'b1;
        mem_waddr = a_r;
        if (fct_pkg::chain_end(walk_d)) begin
          fin     = 1'b1;
          fin_res = EW'(cnt_inc);
        end else if ({1'b0, walk_d} >= CW'(lim_r)) begin
          fin     = 1'b1;
          fin_res = EW'(cnt_inc);
          fin_st  = fct_pkg::ST_RANGE;
        end else if (cnt_inc >= lim_r) begin
          fin     = 1'b1;
          fin_res = EW'(cnt_inc);
          fin_st  = fct_pkg::ST_LOOP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = walk_d[AW-1:0];
          a_nxt     = walk_d[AW-1:0];
          cnt_nxt   = cnt_inc;
          // the read lands together with this zeroing write
          fwd_nxt   = (walk_d[AW-1:0] == a_r);
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase

    if (fin) begin
      state_nxt = slot_free ? S_IDLE : S_DONE;
    end
  end

  assign out_load      = (fin || (state_r == S_DONE)) && slot_free;
  assign out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      lim_r       <= lim_rst;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      lim_r       <= lim_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    cnt_r <= cnt_nxt;
    fwd_r <= fwd_nxt;
    if (fin) begin
      res_r <= fin_res;
      st_r  <= fin_st;
    end
    if (out_load) begin
      out_res_r <= fin ? fin_res : res_r;
      out_st_r  <= fin ? fin_st : st_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_res_r;
  assign out_ch.status       = out_st_r;

  // an idle-state write to the table only comes from an accepted write word
  `ASSERT_IMPL(a_idle_write, mem_we && (state_r == S_IDLE), in_acc && (in_ch.op == fct_pkg::OP_WRITE))
  // the scan stays inside 2 .. limit-1
  `ASSERT_IMPL(a_alloc_bounds, state_r == S_ALLOC, (a_r >= AW'(2)) && (LW'(a_r) < lim_r))
  // the walk never holds more freed entries than the limit
  `ASSERT_IMPL(a_free_count, state_r == S_FREE, (cnt_r < lim_r) && (LW'(a_r) < lim_r))
  // a finished word with a blocked output goes through the done state
  `ASSERT_NEXT(a_done_hold, fin && !slot_free, (state_r == S_DONE) && out_valid_r)

endmodule

// ===== tb/fct_answer_checker.sv =====
`timescale 1ns / 1ps
// fct_answer_checker: keeps a shadow copy of the allocation table and of fat_sectors,
// predicts the result word of every accepted request and compares it in order
// depends on fct_pkg and the channel interfaces in fct_if.sv
module fct_answer_checker #(
  parameter int MAX_ENTRIES = fct_pkg::MAX_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  fct_req_if                          req,
  fct_rsp_if                          rsp,
  input  logic                        cfg_we,
  input  logic [fct_pkg::SECT_W-1:0]  cfg_wdata,
  output int unsigned                 mismatches,
  output int unsigned                 pending_words
);

  typedef struct packed {
    logic [fct_pkg::ENTRY_W-1:0] result_value;
    logic [fct_pkg::ST_W-1:0]    status;
  } fat_answer_t;

  logic [fct_pkg::ENTRY_W-1:0] shadow_fat [MAX_ENTRIES];
  logic [fct_pkg::SECT_W-1:0]  shadow_sectors;
  fat_answer_t                 answers_due [$];
  int unsigned                 fail_count = 0;

  // updates the shadow table and returns the word the engine should give
  function automatic fat_answer_t apply_fat_request(input logic [fct_pkg::OP_W-1:0] op,
                                                    input logic [fct_pkg::ENTRY_W-1:0] start,
                                                    input logic [fct_pkg::ENTRY_W-1:0] value);
    int unsigned                 lim;
    int unsigned                 freed;
    logic [fct_pkg::ENTRY_W-1:0] cl;
    logic [fct_pkg::ENTRY_W-1:0] nxt;
    fat_answer_t                 ans;
    lim = (32'(shadow_sectors) * 1024) / 3;
    if (lim > MAX_ENTRIES) lim = MAX_ENTRIES;
    ans.result_value = '0;
    ans.status = fct_pkg::ST_OK;
    cl = start;
    freed = 0;
    case (op)
      fct_pkg::OP_READ: begin
        if (cl < lim) ans.result_value = shadow_fat[cl];
        else ans.status = fct_pkg::ST_RANGE;
      end
      fct_pkg::OP_WRITE: begin
        if (cl < lim) shadow_fat[cl] = value;
        else ans.status = fct_pkg::ST_RANGE;
      end
      fct_pkg::OP_ALLOC: begin
        ans.status = fct_pkg::ST_FULL;
        for (int c = 2; c < lim; c++) begin
          if (shadow_fat[c] == '0) begin
            shadow_fat[c] = fct_pkg::END_MARK;
            ans.result_value = fct_pkg::ENTRY_W'(c);
            ans.status = fct_pkg::ST_OK;
            break;
          end
        end
      end
      default: begin
        // walk ends on 0, 1 or the reserved/end-of-chain marks
        while (cl >= 2 && cl < fct_pkg::CHAIN_TOP) begin
          if (cl >= lim) begin
            ans.status = fct_pkg::ST_RANGE;
            break;
          end
          if (freed >= lim) begin
            ans.status = fct_pkg::ST_LOOP;
            break;
          end
          nxt = shadow_fat[cl];
          shadow_fat[cl] = '0;
          freed++;
          cl = nxt;
        end
        ans.result_value = fct_pkg::ENTRY_W'(freed);
      end
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    fat_answer_t want;
    if (!rst_n) begin
      foreach (shadow_fat[i]) shadow_fat[i] = '0;
      shadow_sectors = fct_pkg::FAT_SECTORS_RST;
      answers_due.delete();
    end else begin
      if (cfg_we) shadow_sectors = cfg_wdata;
      // pop before push: a word leaving can never belong to a request entering now
      if (rsp.valid && rsp.ready) begin
        if (answers_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result word: result_value %03h status %0d",
                     rsp.result_value, rsp.status);
        end else begin
          want = answers_due.pop_front();
          if (rsp.result_value !== want.result_value || rsp.status !== want.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result word mismatch: result_value exp %03h got %03h, status exp %0d got %0d",
                       want.result_value, rsp.result_value, want.status, rsp.status);
          end
        end
      end
      if (req.valid && req.ready)
        answers_due.push_back(apply_fat_request(req.op, req.cluster, req.entry_value));
    end
    mismatches <= fail_count;
    pending_words <= answers_due.size();
  end

endmodule

// ===== tb/fat12_cluster_table_engine_top_tb.sv =====
`timescale 1ns / 1ps
// fat12_cluster_table_engine_top_tb: drives requests, fat_sectors and output back-pressure
// and gives the verdict; depends on fct_pkg, fct_if.sv, fct_answer_checker and the rtl top
module fat12_cluster_table_engine_top_tb;

  localparam int RX_HOLD_CYCLES = 300;
  localparam int EW = fct_pkg::ENTRY_W;

  typedef enum int unsigned {RX_ALWAYS, RX_COIN, RX_RARE_STALL, RX_PERIODIC} rx_mode_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_we;
  logic [fct_pkg::SECT_W-1:0] cfg_wdata;
  int unsigned                mismatches;
  int unsigned                pending_words;

  bit          hold_request;
  bit          bus_held;
  int unsigned burst_left;
  int unsigned items_sent;
  int unsigned cur_limit;
  int unsigned sweep [16] = '{9, 15, 12, 2, 0, 13, 4, 14, 1, 10, 11, 3, 5, 6, 7, 8};

  fct_req_if in_ch ();
  fct_rsp_if out_ch ();

  fat12_cluster_table_engine_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  fct_answer_checker answer_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (in_ch),
    .rsp           (out_ch),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .pending_words (pending_words)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #200ms;
    $display("fat12_cluster_table_engine_top regression: fail");
    $finish;
  end

  // result side back-pressure
  initial begin
    rx_mode_t    mode;
    int unsigned mode_left;
    int unsigned tick;
    out_ch.ready <= 1'b0;
    mode = RX_ALWAYS;
    mode_left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        tick++;
        case (mode)
          RX_ALWAYS:     out_ch.ready <= 1'b1;
          RX_COIN:       out_ch.ready <= 1'($urandom_range(0, 1));
          RX_RARE_STALL: out_ch.ready <= ($urandom_range(0, 7) != 0);
          default:       out_ch.ready <= ((tick % 5) < 2);
        endcase
      end
    end
  end

  task automatic push_request(input logic [fct_pkg::OP_W-1:0] op, input logic [EW-1:0] cl,
                              input logic [EW-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      if (gap != 0) begin
        if (bus_held) in_ch.valid <= 1'b0;
        bus_held = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.cluster <= cl;
    in_ch.entry_value <= value;
    bus_held = 1'b1;
    items_sent++;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  task automatic drain_results();
    if (bus_held) in_ch.valid <= 1'b0;
    bus_held = 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  task automatic set_sectors(input int unsigned s);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= fct_pkg::SECT_W'(s);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_limit = (s * 1024) / 3;
    if (cur_limit > fct_pkg::MAX_ENTRIES_DEF) cur_limit = fct_pkg::MAX_ENTRIES_DEF;
  endtask

  // mostly the low clusters where chains live, then around the limit and the chain marks
  function automatic logic [EW-1:0] pick_cluster();
    int unsigned r;
    int unsigned lo;
    int unsigned hi;
    r = $urandom_range(0, 99);
    lo = (cur_limit > 2) ? cur_limit - 2 : 0;
    hi = (cur_limit + 1 > 4095) ? 4095 : cur_limit + 1;
    if (r < 50) return EW'($urandom_range(0, 63));
    else if (r < 70) return EW'($urandom_range(lo, hi));
    else if (r < 80) begin
      if ($urandom_range(0, 1) == 0) return EW'($urandom_range(0, 1));
      else return EW'($urandom_range(fct_pkg::CHAIN_TOP, fct_pkg::END_MARK));
    end else return EW'($urandom());
  endfunction

  function automatic logic [EW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return EW'($urandom_range(2, 63));
    else if (r < 55) return EW'($urandom_range(fct_pkg::CHAIN_TOP, fct_pkg::END_MARK));
    else if (r < 65) return '0;
    else if (r < 75) return pick_cluster();
    else return EW'($urandom());
  endfunction

  // link a short chain through low clusters, maybe peek at it, then free it
  task automatic chain_sequence();
    int unsigned   len;
    int unsigned   r;
    logic [EW-1:0] head;
    logic [EW-1:0] cur;
    logic [EW-1:0] nxt;
    logic [EW-1:0] tail;
    len = $urandom_range(1, 8);
    head = EW'($urandom_range(2, 63));
    cur = head;
    for (int i = 1; i < len; i++) begin
      nxt = EW'($urandom_range(2, 63));
      push_request(fct_pkg::OP_WRITE, cur, nxt);
      cur = nxt;
    end
    r = $urandom_range(0, 9);
    if (r < 7) tail = fct_pkg::END_MARK;
    else if (r < 8) tail = EW'($urandom_range(fct_pkg::CHAIN_TOP, fct_pkg::END_MARK - 1));
    else tail = pick_cluster();
    push_request(fct_pkg::OP_WRITE, cur, tail);
    if ($urandom_range(0, 3) == 0) push_request(fct_pkg::OP_READ, head, EW'($urandom()));
    push_request(fct_pkg::OP_FREE, head, EW'($urandom()));
  endtask

  task automatic random_items(input int unsigned n);
    int unsigned stop_at;
    int unsigned r;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 35) chain_sequence();
      else if (r < 58) push_request(fct_pkg::OP_READ, pick_cluster(), EW'($urandom()));
      else if (r < 78) push_request(fct_pkg::OP_WRITE, pick_cluster(), pick_value());
      else if (r < 90) push_request(fct_pkg::OP_ALLOC, EW'($urandom()), EW'($urandom()));
      else push_request(fct_pkg::OP_FREE, pick_cluster(), EW'($urandom()));
    end
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.op <= fct_pkg::OP_READ;
    in_ch.cluster <= '0;
    in_ch.entry_value <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= fct_pkg::FAT_SECTORS_RST;
    rst_n <= 1'b0;
    hold_request = 1'b0;
    bus_held = 1'b0;
    burst_left = 0;
    items_sent = 0;
    cur_limit = 3072;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting, limit 3072
    push_request(fct_pkg::OP_READ, 12'd0, 12'hFFF);
    push_request(fct_pkg::OP_READ, 12'd4095, 12'd0);
    push_request(fct_pkg::OP_WRITE, 12'd5, 12'hABC);
    push_request(fct_pkg::OP_READ, 12'd5, 12'd0);
    push_request(fct_pkg::OP_WRITE, 12'd3071, 12'hFFF);
    push_request(fct_pkg::OP_READ, 12'd3071, 12'd0);
    push_request(fct_pkg::OP_WRITE, 12'd3072, 12'h555);
    push_request(fct_pkg::OP_ALLOC, 12'hFFF, 12'hFFF);
    push_request(fct_pkg::OP_ALLOC, 12'd0, 12'd0);
    push_request(fct_pkg::OP_ALLOC, 12'h2A5, 12'h5A2);
    push_request(fct_pkg::OP_ALLOC, 12'd77, 12'd0);
    push_request(fct_pkg::OP_FREE, 12'd0, 12'd0);
    push_request(fct_pkg::OP_FREE, 12'd1, 12'd0);
    push_request(fct_pkg::OP_FREE, fct_pkg::CHAIN_TOP, 12'd0);
    push_request(fct_pkg::OP_FREE, fct_pkg::END_MARK, 12'd0);
    push_request(fct_pkg::OP_WRITE, 12'd10, 12'd11);
    push_request(fct_pkg::OP_WRITE, 12'd11, 12'd12);
    push_request(fct_pkg::OP_WRITE, 12'd12, fct_pkg::END_MARK);
    push_request(fct_pkg::OP_FREE, 12'd10, 12'd0);
    // chain that leaves the table partway
    push_request(fct_pkg::OP_WRITE, 12'd20, 12'd3500);
    push_request(fct_pkg::OP_FREE, 12'd20, 12'd0);
    // two entries pointing at each other
    push_request(fct_pkg::OP_WRITE, 12'd30, 12'd31);
    push_request(fct_pkg::OP_WRITE, 12'd31, 12'd30);
    push_request(fct_pkg::OP_FREE, 12'd30, 12'd0);
    push_request(fct_pkg::OP_FREE, 12'hFEF, 12'd0);

    // smallest nonzero table: allocate past the end to hit table full
    set_sectors(1);
    repeat (cur_limit + 4) push_request(fct_pkg::OP_ALLOC, EW'($urandom()), EW'($urandom()));
    push_request(fct_pkg::OP_READ, EW'(cur_limit - 1), 12'd0);
    push_request(fct_pkg::OP_READ, EW'(cur_limit), 12'd0);

    foreach (sweep[p]) begin
      set_sectors(sweep[p]);
      if (p % 6 == 0) hold_request = 1'b1;
      random_items(24);
      if (p % 2 == 1) drain_results();
      random_items(24);
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("fat12_cluster_table_engine_top regression: pass");
    end else begin
      $display("fat12_cluster_table_engine_top regression: fail");
    end
    $finish;
  end

endmodule
